FILE: rtl/assert_macros.svh
// Assertion helpers shared by the calibrator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge while reset is released.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A plain condition that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    `ASSERT_AT(lbl, clk, rst_n, (expr), msg)

`endif

FILE: rtl/dqsrw_pkg.sv
`timescale 1ns / 1ps
package dqsrw_pkg;

    localparam int TAPS_DEF   = 32;
    localparam int LANES_DEF  = 4;
    localparam int ROUNDS_DEF = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN    = 2'd2;

    localparam logic [7:0] MATCH_BYTE_RST  = 8'h55;
    localparam logic [4:0] EDGE_OFFSET_RST = 5'd9;
    localparam logic [4:0] MIN_SPAN_RST    = 5'd10;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_BITSLIP = 2'd1,
        ST_FAILED  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] match_byte;
        logic [4:0] edge_offset;
        logic [4:0] min_span;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [1:0] chosen_lane;
        logic [4:0] chosen_tap;
        logic [1:0] round_index;
        logic [4:0] window_first;
        logic [4:0] window_last;
    } t_result;

endpackage

FILE: rtl/dqsrw_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dqsrw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNTW'(DEPTH), "fifo count overrun")
    `ASSERT_AT(a_push_fills, i_clk, i_rst_n, wr_en && !rd_en |=> !o_empty, "fifo lost a beat")

endmodule

FILE: rtl/dqsrw_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dqsrw_front
    import dqsrw_pkg::*;
#(
    parameter int TAPS  = TAPS_DEF,
    parameter int LANES = LANES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_push,
    input  logic [31:0]                   i_sample,
    input  logic                          i_sum_full,
    output logic                          o_sum_push,
    output logic [LANES-1:0]              o_sum_valid,
    output logic [LANES-1:0][$clog2(TAPS)-1:0] o_sum_first,
    output logic [LANES-1:0][$clog2(TAPS)-1:0] o_sum_last
);

    localparam int TW = $clog2(TAPS);

    logic [TW-1:0]             r_tap;
    logic [LANES-1:0]          r_in_run;
    logic [LANES-1:0][TW-1:0]  r_start;
    logic [LANES-1:0]          r_best_valid;
    logic [LANES-1:0][TW-1:0]  r_best_first;
    logic [LANES-1:0][TW-1:0]  r_best_last;

    logic [LANES-1:0]          n_in_run;
    logic [LANES-1:0][TW-1:0]  n_start;
    logic [LANES-1:0]          n_best_valid;
    logic [LANES-1:0][TW-1:0]  n_best_first;
    logic [LANES-1:0][TW-1:0]  n_best_last;

    logic                      accept;
    logic                      at_end;
    logic [8*LANES+31:0]       sample_ext;

    assign accept     = i_push && !i_sum_full;
    assign at_end     = (r_tap == TW'(TAPS - 1));
    // Lanes above the four in the word read as zero bytes.
    assign sample_ext = {(8 * LANES)'(0), i_sample};

    always_comb begin
        logic [7:0]    lane_byte;
        logic          hit;
        logic          do_close;
        logic [TW-1:0] c_first;
        logic [TW-1:0] c_last;
        logic [TW-1:0] span;
        logic [TW-1:0] best;
        n_in_run     = r_in_run;
        n_start      = r_start;
        n_best_valid = r_best_valid;
        n_best_first = r_best_first;
        n_best_last  = r_best_last;
        for (int k = 0; k < LANES; k++) begin
            lane_byte = sample_ext[k*8 +: 8];
            hit       = (lane_byte == i_cfg.match_byte);
            do_close  = 1'b0;
            c_first   = r_start[k];
            c_last    = r_tap;
            if (hit) begin
                if (!r_in_run[k]) begin
                    n_in_run[k] = 1'b1;
                    n_start[k]  = r_tap;
                    c_first     = r_tap;
                end
                do_close = at_end;
            end else if (r_in_run[k]) begin
                do_close = 1'b1;
                c_last   = r_tap - 1'b1;
            end
            span = c_last - c_first;
            best = r_best_valid[k] ? (r_best_last[k] - r_best_first[k]) : '0;
            if (do_close) begin
                n_in_run[k] = 1'b0;
                if (span > best) begin
                    n_best_valid[k] = 1'b1;
                    n_best_first[k] = c_first;
                    n_best_last[k]  = c_last;
                end
            end
        end
    end

    assign o_sum_push  = accept && at_end;
    assign o_sum_valid = n_best_valid;
    assign o_sum_first = n_best_first;
    assign o_sum_last  = n_best_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap        <= '0;
            r_in_run     <= '0;
            r_best_valid <= '0;
        end else if (accept) begin
            if (at_end) begin
                r_tap        <= '0;
                r_in_run     <= '0;
                r_best_valid <= '0;
            end else begin
                r_tap        <= r_tap + 1'b1;
                r_in_run     <= n_in_run;
                r_best_valid <= n_best_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start      <= n_start;
            r_best_first <= n_best_first;
            r_best_last  <= n_best_last;
        end
    end

    `ASSERT_AT(a_tap_wraps, i_clk, i_rst_n, o_sum_push |=> r_tap == '0, "tap did not wrap")
    `ASSERT_ALWAYS(a_tap_range, i_clk, i_rst_n, r_tap <= TW'(TAPS - 1), "tap out of range")

endmodule

FILE: rtl/dqsrw_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dqsrw_back
    import dqsrw_pkg::*;
#(
    parameter int TAPS   = TAPS_DEF,
    parameter int LANES  = LANES_DEF,
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cfg                               i_cfg,
    input  logic                               i_sum_empty,
    input  logic [LANES-1:0]                   i_sum_valid,
    input  logic [LANES-1:0][$clog2(TAPS)-1:0] i_sum_first,
    input  logic [LANES-1:0][$clog2(TAPS)-1:0] i_sum_last,
    output logic                               o_sum_pop,
    input  logic                               i_res_full,
    output logic                               o_res_push,
    output t_result                            o_res
);

    localparam int TW = $clog2(TAPS);
    localparam int CW = ((TW > 5) ? TW : 5) + 1;
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    logic [RW-1:0]            r_round;
    logic [LANES-1:0]         lane_ok;
    logic [LANES-1:0][CW-1:0] lane_tap;
    logic                     found;
    logic [LW-1:0]            sel;
    logic                     last_round;

    // Tap choice for each lane, from its best window.
    always_comb begin
        logic [CW-1:0] fe;
        logic [CW-1:0] le;
        logic [CW-1:0] oe;
        logic [CW-1:0] me;
        logic          ok;
        logic [CW-1:0] c;
        oe = CW'(i_cfg.edge_offset);
        me = CW'(i_cfg.min_span);
        for (int k = 0; k < LANES; k++) begin
            fe = CW'(i_sum_first[k]);
            le = CW'(i_sum_last[k]);
            ok = 1'b0;
            c  = '0;
            if (i_sum_valid[k]) begin
                if (fe == '0 && le > oe) begin
                    ok = 1'b1;
                    c  = le - oe;
                end else if (le == CW'(TAPS - 1) && (fe + oe) < CW'(TAPS)) begin
                    ok = 1'b1;
                    c  = fe + oe;
                end else if ((le - fe) > me) begin
                    ok = 1'b1;
                    c  = (le + fe) >> 1;
                end
            end
            lane_ok[k]  = ok && (c != '0);
            lane_tap[k] = c;
        end
    end

    // Lowest qualifying lane wins.
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (lane_ok[k]) begin
                found = 1'b1;
                sel   = LW'(k);
            end
        end
    end

    assign last_round = (r_round == RW'(ROUNDS - 1));
    assign o_sum_pop  = !i_sum_empty && !i_res_full;
    assign o_res_push = o_sum_pop;

    always_comb begin
        o_res             = '0;
        o_res.round_index = 2'(r_round);
        if (found) begin
            o_res.status       = ST_FOUND;
            o_res.chosen_lane  = 2'(sel);
            o_res.chosen_tap   = 5'(lane_tap[sel]);
            o_res.window_first = 5'(i_sum_first[sel]);
            o_res.window_last  = 5'(i_sum_last[sel]);
        end else if (last_round) begin
            o_res.status = ST_FAILED;
        end else begin
            o_res.status = ST_BITSLIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
        end else if (o_sum_pop) begin
            r_round <= (found || last_round) ? '0 : r_round + 1'b1;
        end
    end

    `ASSERT_ALWAYS(a_round_range, i_clk, i_rst_n, r_round <= RW'(ROUNDS - 1), "round overrun")
    `ASSERT_AT(a_done_restarts, i_clk, i_rst_n, o_sum_pop && found |=> r_round == '0, "no restart")

endmodule

FILE: rtl/dqs_read_window_calibrator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Beat
// sample    in         push / full          i_strobe_sample, one per delay tap
// result    out        pop / empty          o_status .. o_window_last, one per round
// config    in         i_cfg_we (no stall)  i_cfg_idx, i_cfg_wdata
//
// A sample beat is taken every cycle while full is low.
// The result of a round passes from its last tap through the round summary queue,
// then through the lane choice into the result queue.
// full rises only when the two-entry summary queue holds rounds not yet judged,
// which happens only while the result queue is itself held by a low pop.
// Reset is synchronous; it clears the tap, run and round state and the queue pointers, and loads the config registers.
module dqs_read_window_calibrator
    import dqsrw_pkg::*;
#(
    parameter int TAPS   = TAPS_DEF,
    parameter int LANES  = LANES_DEF,
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [31:0]           i_strobe_sample,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_status,
    output logic [1:0]            o_chosen_lane,
    output logic [4:0]            o_chosen_tap,
    output logic [1:0]            o_round_index,
    output logic [4:0]            o_window_first,
    output logic [4:0]            o_window_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int TW     = $clog2(TAPS);
    localparam int SUM_W  = LANES * (1 + 2 * TW);
    localparam int RES_W  = $bits(t_result);
    localparam int Q_DEPTH = 2;

    t_cfg                     r_cfg;

    logic                     sum_push;
    logic                     sum_full;
    logic                     sum_pop;
    logic                     sum_empty;
    logic [LANES-1:0]         front_valid;
    logic [LANES-1:0][TW-1:0] front_first;
    logic [LANES-1:0][TW-1:0] front_last;
    logic [SUM_W-1:0]         sum_wdata;
    logic [SUM_W-1:0]         sum_rdata;
    logic [LANES-1:0]         back_valid;
    logic [LANES-1:0][TW-1:0] back_first;
    logic [LANES-1:0][TW-1:0] back_last;

    logic                     res_push;
    logic                     res_full;
    t_result                  res_in;
    logic [RES_W-1:0]         res_rdata;
    t_result                  res_out;

    // Configuration registers: writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_byte  <= MATCH_BYTE_RST;
            r_cfg.edge_offset <= EDGE_OFFSET_RST;
            r_cfg.min_span    <= MIN_SPAN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MATCH_BYTE: begin
                    r_cfg.match_byte <= i_cfg_wdata;
                end
                REG_EDGE_OFFSET: begin
                    r_cfg.edge_offset <= i_cfg_wdata[4:0];
                end
                REG_MIN_SPAN: begin
                    r_cfg.min_span <= i_cfg_wdata[4:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: per-lane run tracking, one tap per cycle while push is high and the summary queue is not full.
    dqsrw_front #(
        .TAPS  (TAPS),
        .LANES (LANES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_sample    (i_strobe_sample),
        .i_sum_full  (sum_full),
        .o_sum_push  (sum_push),
        .o_sum_valid (front_valid),
        .o_sum_first (front_first),
        .o_sum_last  (front_last)
    );

    assign full      = sum_full;
    assign sum_wdata = {front_valid, front_first, front_last};

    // Round summaries wait here, so a new round can start while the last is judged.
    dqsrw_fifo #(
        .WIDTH (SUM_W),
        .DEPTH (Q_DEPTH)
    ) u_sum_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sum_push),
        .i_data  (sum_wdata),
        .o_full  (sum_full),
        .i_pop   (sum_pop),
        .o_empty (sum_empty),
        .o_data  (sum_rdata)
    );

    assign {back_valid, back_first, back_last} = sum_rdata;

    // Back end: lane choice and round bookkeeping.
    dqsrw_back #(
        .TAPS   (TAPS),
        .LANES  (LANES),
        .ROUNDS (ROUNDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_sum_empty (sum_empty),
        .i_sum_valid (back_valid),
        .i_sum_first (back_first),
        .i_sum_last  (back_last),
        .o_sum_pop   (sum_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue; its head drives the result ports.
    dqsrw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_rdata)
    );

    assign res_out        = t_result'(res_rdata);
    assign o_status       = res_out.status;
    assign o_chosen_lane  = res_out.chosen_lane;
    assign o_chosen_tap   = res_out.chosen_tap;
    assign o_round_index  = res_out.round_index;
    assign o_window_first = res_out.window_first;
    assign o_window_last  = res_out.window_last;

endmodule
